>>> rtl/spo_pkg.sv
// Shared types and constants for the shape pair overlap test.
// Holds the shape kind encoding and the flags that travel with each queued item.
// No dependencies.
`timescale 1ns / 1ps

package spo_pkg;

  typedef enum logic [2:0] {
    KIND_BOX    = 3'd0,
    KIND_CIRCLE = 3'd1,
    KIND_VCAP   = 3'd2,
    KIND_HCAP   = 3'd3,
    KIND_POINT  = 3'd4
  } kind_e;

  typedef struct packed {
    logic invalid;
    logic same_axis;
    logic vertical;
  } flags_t;

  localparam int QueueDepth = 4;

endpackage

>>> rtl/spo_fifo.sv
// Small first-word-fall-through queue used between the front and back parts
// and on the result side. Depends on nothing.
`timescale 1ns / 1ps

module spo_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/spo_front.sv
// Front part: classifies a shape pair and splits each shape into a core box
// and up to two circles. Depends on spo_pkg.
`timescale 1ns / 1ps

module spo_front #(
  parameter int C = 16
) (
  input  logic [2:0]            a_kind_i,
  input  logic [C-1:0]          a_x_i,
  input  logic [C-1:0]          a_y_i,
  input  logic [C-2:0]          a_half_width_i,
  input  logic [C-2:0]          a_half_height_i,
  input  logic [2:0]            b_kind_i,
  input  logic [C-1:0]          b_x_i,
  input  logic [C-1:0]          b_y_i,
  input  logic [C-2:0]          b_half_width_i,
  input  logic [C-2:0]          b_half_height_i,
  output spo_pkg::flags_t       flags_o,
  output logic [1:0]            box_v_o,
  output logic [1:0][C:0]       box_x_o,
  output logic [1:0][C:0]       box_y_o,
  output logic [1:0][C-2:0]     box_w_o,
  output logic [1:0][C-2:0]     box_h_o,
  output logic [1:0][1:0]       circ_v_o,
  output logic [1:0][1:0][C:0]  circ_x_o,
  output logic [1:0][1:0][C:0]  circ_y_o,
  output logic [1:0][C-2:0]     rad_o
);

  localparam int P = C + 1;
  localparam int H = C - 1;

  logic [1:0][2:0]   kind;
  logic [1:0][C-1:0] xs, ys;
  logic [1:0][H-1:0] hw, hh, dd;
  logic [1:0][P-1:0] xe, ye, de;

  assign kind = {b_kind_i, a_kind_i};
  assign xs   = {b_x_i, a_x_i};
  assign ys   = {b_y_i, a_y_i};
  assign hw   = {b_half_width_i, a_half_width_i};
  assign hh   = {b_half_height_i, a_half_height_i};

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      dd[s] = (hh[s] >= hw[s]) ? hh[s] - hw[s] : hw[s] - hh[s];
      xe[s] = {xs[s][C-1], xs[s]};
      ye[s] = {ys[s][C-1], ys[s]};
      de[s] = {2'b00, dd[s]};
      box_v_o[s]     = 1'b0;
      box_x_o[s]     = xe[s];
      box_y_o[s]     = ye[s];
      box_w_o[s]     = hw[s];
      box_h_o[s]     = hh[s];
      circ_v_o[s]    = 2'b00;
      circ_x_o[s][0] = xe[s];
      circ_x_o[s][1] = xe[s];
      circ_y_o[s][0] = ye[s];
      circ_y_o[s][1] = ye[s];
      rad_o[s]       = hw[s];
      case (spo_pkg::kind_e'(kind[s]))
        spo_pkg::KIND_BOX: begin
          box_v_o[s] = 1'b1;
        end
        spo_pkg::KIND_CIRCLE: begin
          circ_v_o[s] = 2'b01;
        end
        spo_pkg::KIND_POINT: begin
          circ_v_o[s] = 2'b01;
          rad_o[s]    = '0;
        end
        spo_pkg::KIND_VCAP: begin
          box_v_o[s]     = 1'b1;
          box_h_o[s]     = dd[s];
          circ_v_o[s]    = 2'b11;
          circ_y_o[s][0] = ye[s] + de[s];
          circ_y_o[s][1] = ye[s] - de[s];
        end
        spo_pkg::KIND_HCAP: begin
          box_v_o[s]     = 1'b1;
          box_w_o[s]     = dd[s];
          circ_v_o[s]    = 2'b11;
          circ_x_o[s][0] = xe[s] + de[s];
          circ_x_o[s][1] = xe[s] - de[s];
          rad_o[s]       = hh[s];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    flags_o.invalid = (a_kind_i > spo_pkg::KIND_POINT) || (b_kind_i > spo_pkg::KIND_POINT) ||
                      ((a_kind_i == spo_pkg::KIND_POINT) && (b_kind_i == spo_pkg::KIND_POINT));
    flags_o.same_axis = (a_kind_i == b_kind_i) &&
                        ((a_kind_i == spo_pkg::KIND_VCAP) || (a_kind_i == spo_pkg::KIND_HCAP));
    flags_o.vertical = (a_kind_i == spo_pkg::KIND_VCAP);
  end

endmodule

>>> rtl/spo_back.sv
// Back part: pipeline that runs eight distance lanes, the box tests and the
// same-axis capsule test, then merges them. Depends on spo_pkg.
`timescale 1ns / 1ps

module spo_back #(
  parameter int C = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  input  spo_pkg::flags_t       flags_i,
  input  logic [1:0]            box_v_i,
  input  logic [1:0][C:0]       box_x_i,
  input  logic [1:0][C:0]       box_y_i,
  input  logic [1:0][C-2:0]     box_w_i,
  input  logic [1:0][C-2:0]     box_h_i,
  input  logic [1:0][1:0]       circ_v_i,
  input  logic [1:0][1:0][C:0]  circ_x_i,
  input  logic [1:0][1:0][C:0]  circ_y_i,
  input  logic [1:0][C-2:0]     rad_i,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output logic                  res_overlap_o
);

  localparam int P     = C + 1;
  localparam int H     = C - 1;
  localparam int W     = C + 2;
  localparam int LANES = 8;

  function automatic logic signed [W-1:0] ext_p(input logic [P-1:0] v);
    return $signed({v[P-1], v});
  endfunction

  function automatic logic signed [W-1:0] ext_h(input logic [H-1:0] v);
    return $signed({{(W-H){1'b0}}, v});
  endfunction

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  logic en;

  logic signed [W-1:0] bx [2], by [2], bw [2], bh [2], rw [2];
  logic signed [W-1:0] lox [2], hix [2], loy [2], hiy [2];
  logic signed [W-1:0] cx, cy, qx, qy, ca, cb, aa, ab, ad, bd;
  logic signed [W-1:0] dx_d [LANES], dy_d [LANES];
  logic [C-1:0]        r_d [LANES];
  logic [LANES-1:0]    m_d, in_d;
  logic                bb_d, gate_d, span_d;

  logic                v1_q, v2_q;
  spo_pkg::flags_t     f1_q, f2_q;
  logic                bb1_q, gate1_q, span1_q, bb2_q, gate2_q, span2_q;
  logic signed [W-1:0] dx1_q [LANES], dy1_q [LANES];
  logic [C-1:0]        r1_q [LANES];
  logic [LANES-1:0]    m1_q, in1_q, m2_q, in2_q;
  logic [2*W-1:0]      x2_q [LANES], y2_q [LANES];
  logic [2*C-1:0]      rr2_q [LANES];
  logic [LANES-1:0]    lt;
  logic [2*W:0]        sum;
  logic                hit;

  assign en         = !res_full_i;
  assign item_pop_o = en && item_valid_i;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      bx[s]  = ext_p(box_x_i[s]);
      by[s]  = ext_p(box_y_i[s]);
      bw[s]  = ext_h(box_w_i[s]);
      bh[s]  = ext_h(box_h_i[s]);
      rw[s]  = ext_h(rad_i[s]);
      lox[s] = bx[s] - bw[s];
      hix[s] = bx[s] + bw[s];
      loy[s] = by[s] - bh[s];
      hiy[s] = by[s] + bh[s];
    end
    bb_d = box_v_i[0] && box_v_i[1] && (lox[0] < hix[1]) && (hix[0] > lox[1]) &&
           (loy[0] < hiy[1]) && (hiy[0] > loy[1]);
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < 2; j++) begin
        cx = ext_p(circ_x_i[1-s][j]);
        cy = ext_p(circ_y_i[1-s][j]);
        qx = (cx < lox[s]) ? lox[s] : ((cx > hix[s]) ? hix[s] : cx);
        qy = (cy < loy[s]) ? loy[s] : ((cy > hiy[s]) ? hiy[s] : cy);
        dx_d[s*2+j] = cx - qx;
        dy_d[s*2+j] = cy - qy;
        r_d[s*2+j]  = {1'b0, rad_i[1-s]};
        m_d[s*2+j]  = box_v_i[s] && circ_v_i[1-s][j];
        in_d[s*2+j] = (lox[s] < cx) && (hix[s] > cx) && (loy[s] < cy) && (hiy[s] > cy);
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        dx_d[4+i*2+j] = ext_p(circ_x_i[0][i]) - ext_p(circ_x_i[1][j]);
        dy_d[4+i*2+j] = ext_p(circ_y_i[0][i]) - ext_p(circ_y_i[1][j]);
        r_d[4+i*2+j]  = {1'b0, rad_i[0]} + {1'b0, rad_i[1]};
        m_d[4+i*2+j]  = circ_v_i[0][i] && circ_v_i[1][j];
        in_d[4+i*2+j] = 1'b0;
      end
    end
    if (flags_i.vertical) begin
      ca = bx[0];
      cb = bx[1];
      aa = by[0];
      ab = by[1];
      ad = bh[0];
      bd = bh[1];
    end else begin
      ca = by[0];
      cb = by[1];
      aa = bx[0];
      ab = bx[1];
      ad = bw[0];
      bd = bw[1];
    end
    gate_d = !(ca - rw[0] > cb + rw[1]) && !(ca + rw[0] < cb - rw[1]);
    span_d = (aa - ad < ab + bd) && (aa + ad > ab - bd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= item_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q    <= flags_i;
      bb1_q   <= bb_d;
      gate1_q <= gate_d;
      span1_q <= span_d;
      m1_q    <= m_d;
      in1_q   <= in_d;
      dx1_q   <= dx_d;
      dy1_q   <= dy_d;
      r1_q    <= r_d;
      f2_q    <= f1_q;
      bb2_q   <= bb1_q;
      gate2_q <= gate1_q;
      span2_q <= span1_q;
      m2_q    <= m1_q;
      in2_q   <= in1_q;
      for (int l = 0; l < LANES; l++) begin
        x2_q[l]  <= (2*W)'(mag_f(dx1_q[l])) * (2*W)'(mag_f(dx1_q[l]));
        y2_q[l]  <= (2*W)'(mag_f(dy1_q[l])) * (2*W)'(mag_f(dy1_q[l]));
        rr2_q[l] <= (2*C)'(r1_q[l]) * (2*C)'(r1_q[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum   = {1'b0, x2_q[l]} + {1'b0, y2_q[l]};
      lt[l] = sum < (2*W+1)'(rr2_q[l]);
    end
    if (f2_q.invalid) begin
      hit = 1'b0;
    end else if (f2_q.same_axis) begin
      hit = gate2_q && (span2_q || lt[5] || lt[6]);
    end else begin
      hit = bb2_q || (|(m2_q & (in2_q | lt)));
    end
  end

  assign res_push_o    = en && v2_q;
  assign res_overlap_o = hit;

endmodule

>>> rtl/shape_pair_overlap_test.sv
// Top level of the shape pair overlap test: front decoder, item queue,
// back pipeline and result queue. Depends on spo_pkg, spo_front, spo_back, spo_fifo.
`timescale 1ns / 1ps

// Takes one shape pair per cycle while full_o is low and returns one overlap bit
// per pair, in order. An accepted pair leaves the item queue into the first back
// stage, then moves into the second back stage and then into the result queue,
// whose head drives the result ports. The pipeline sustains one pair per cycle
// while the result queue is not full. Four-entry queues sit between the front and
// back parts and on the result side, so either side may stall alone.

module shape_pair_overlap_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [2:0]            a_kind_i,
  input  logic [COORD_BITS-1:0] a_x_i,
  input  logic [COORD_BITS-1:0] a_y_i,
  input  logic [COORD_BITS-2:0] a_half_width_i,
  input  logic [COORD_BITS-2:0] a_half_height_i,
  input  logic [2:0]            b_kind_i,
  input  logic [COORD_BITS-1:0] b_x_i,
  input  logic [COORD_BITS-1:0] b_y_i,
  input  logic [COORD_BITS-2:0] b_half_width_i,
  input  logic [COORD_BITS-2:0] b_half_height_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic                  overlap_o
);

  localparam int C      = COORD_BITS;
  localparam int P      = C + 1;
  localparam int H      = C - 1;
  localparam int ITEM_W = $bits(spo_pkg::flags_t) + 6 + 12*P + 6*H;

  spo_pkg::flags_t       f_flags, q_flags;
  logic [1:0]            f_box_v, q_box_v;
  logic [1:0][P-1:0]     f_box_x, f_box_y, q_box_x, q_box_y;
  logic [1:0][H-1:0]     f_box_w, f_box_h, f_rad, q_box_w, q_box_h, q_rad;
  logic [1:0][1:0]       f_circ_v, q_circ_v;
  logic [1:0][1:0][P-1:0] f_circ_x, f_circ_y, q_circ_x, q_circ_y;
  logic [ITEM_W-1:0]     mid_wdata, mid_rdata;
  logic                  mid_empty, mid_pop;
  logic                  res_full, res_push, res_overlap;

  spo_front #(.C(C)) u_front (
    .a_kind_i        (a_kind_i),
    .a_x_i           (a_x_i),
    .a_y_i           (a_y_i),
    .a_half_width_i  (a_half_width_i),
    .a_half_height_i (a_half_height_i),
    .b_kind_i        (b_kind_i),
    .b_x_i           (b_x_i),
    .b_y_i           (b_y_i),
    .b_half_width_i  (b_half_width_i),
    .b_half_height_i (b_half_height_i),
    .flags_o         (f_flags),
    .box_v_o         (f_box_v),
    .box_x_o         (f_box_x),
    .box_y_o         (f_box_y),
    .box_w_o         (f_box_w),
    .box_h_o         (f_box_h),
    .circ_v_o        (f_circ_v),
    .circ_x_o        (f_circ_x),
    .circ_y_o        (f_circ_y),
    .rad_o           (f_rad)
  );

  assign mid_wdata = {f_flags, f_box_v, f_box_x, f_box_y, f_box_w, f_box_h,
                      f_circ_v, f_circ_x, f_circ_y, f_rad};
  assign {q_flags, q_box_v, q_box_x, q_box_y, q_box_w, q_box_h,
          q_circ_v, q_circ_x, q_circ_y, q_rad} = mid_rdata;

  spo_fifo #(.WIDTH(ITEM_W), .DEPTH(spo_pkg::QueueDepth)) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (mid_wdata),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  spo_back #(.C(C)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (!mid_empty),
    .item_pop_o    (mid_pop),
    .flags_i       (q_flags),
    .box_v_i       (q_box_v),
    .box_x_i       (q_box_x),
    .box_y_i       (q_box_y),
    .box_w_i       (q_box_w),
    .box_h_i       (q_box_h),
    .circ_v_i      (q_circ_v),
    .circ_x_i      (q_circ_x),
    .circ_y_i      (q_circ_y),
    .rad_i         (q_rad),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_overlap_o (res_overlap)
  );

  spo_fifo #(.WIDTH(1), .DEPTH(spo_pkg::QueueDepth)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_overlap),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (overlap_o),
    .empty_o (empty_o)
  );

endmodule

>>> rtl/spo_checker.sv
// Port-level checks for the shape pair overlap test, bound to the top level.
// Depends on shape_pair_overlap_test.
`timescale 1ns / 1ps

module spo_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push_i,
  input logic full_o,
  input logic pop_i,
  input logic empty_o,
  input logic overlap_o
);

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty_o && !full_o))
    else $error("Queues not empty after reset.");

  a_full_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(!empty_o))
    else $error("Input side filled while the result side was not stalled.");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> !empty_o)
    else $error("Waiting result was withdrawn.");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> $stable(overlap_o))
    else $error("Waiting result changed before its transaction.");

endmodule

bind shape_pair_overlap_test spo_checker u_spo_checker (.*);

>>> verif/shape_pair_overlap_test_tb.sv
// Testbench for shape_pair_overlap_test: drives shape pairs through the push/full queue
// interface and checks each overlap bit against an exact integer predictor.
// Depends on spo_pkg and the shape_pair_overlap_test RTL.
`timescale 1ns / 1ps

module shape_pair_overlap_test_tb;

  localparam int CB = 16;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [2:0] kind;
    longint x, y, hw, hh;
  } shape_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  logic full_o, empty_o, overlap_o;
  logic [2:0] a_kind_i = '0, b_kind_i = '0;
  logic [CB-1:0] a_x_i = '0, a_y_i = '0, b_x_i = '0, b_y_i = '0;
  logic [CB-2:0] a_hw_i = '0, a_hh_i = '0, b_hw_i = '0, b_hh_i = '0;

  bit expected_overlap[$];
  bit exp_bit;
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 36;

  shape_pair_overlap_test #(.COORD_BITS(CB)) u_dut (
    .clk_i, .rst_ni, .push_i, .full_o,
    .a_kind_i, .a_x_i, .a_y_i, .a_half_width_i(a_hw_i), .a_half_height_i(a_hh_i),
    .b_kind_i, .b_x_i, .b_y_i, .b_half_width_i(b_hw_i), .b_half_height_i(b_hh_i),
    .pop_i, .empty_o, .overlap_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit dist_lt(longint dx, longint dy, longint r);
    return dx * dx + dy * dy < r * r;
  endfunction

  function automatic bit box_box(longint ax, longint ay, longint ahw, longint ahh,
                                 longint bx, longint by, longint bhw, longint bhh);
    return ax - ahw < bx + bhw && ax + ahw > bx - bhw &&
           ay - ahh < by + bhh && ay + ahh > by - bhh;
  endfunction

  function automatic bit box_pt(longint bx, longint by, longint hw, longint hh,
                                longint px, longint py);
    return bx - hw < px && bx + hw > px && by - hh < py && by + hh > py;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit box_circ(longint bx, longint by, longint hw, longint hh,
                                  longint cx, longint cy, longint r);
    if (box_pt(bx, by, hw, hh, cx, cy)) return 1'b1;
    return dist_lt(cx - clampl(cx, bx - hw, bx + hw), cy - clampl(cy, by - hh, by + hh), r);
  endfunction

  function automatic longint cap_len(shape_t s);
    return s.hh > s.hw ? s.hh - s.hw : s.hw - s.hh;
  endfunction

  function automatic void cap_parts(shape_t s, output longint bw, output longint bh,
                                    output longint cx[2], output longint cy[2],
                                    output longint r);
    longint d;
    d = cap_len(s);
    if (s.kind == spo_pkg::KIND_VCAP) begin
      bw = s.hw; bh = d; r = s.hw;
      cx[0] = s.x; cy[0] = s.y + d; cx[1] = s.x; cy[1] = s.y - d;
    end else begin
      bw = d; bh = s.hh; r = s.hh;
      cx[0] = s.x + d; cy[0] = s.y; cx[1] = s.x - d; cy[1] = s.y;
    end
  endfunction

  function automatic bit shape_has_point(shape_t s, longint px, longint py);
    longint bw, bh, cx[2], cy[2], r;
    if (s.kind == spo_pkg::KIND_BOX) return box_pt(s.x, s.y, s.hw, s.hh, px, py);
    if (s.kind == spo_pkg::KIND_CIRCLE) return dist_lt(s.x - px, s.y - py, s.hw);
    cap_parts(s, bw, bh, cx, cy, r);
    return box_pt(s.x, s.y, bw, bh, px, py) || dist_lt(cx[0] - px, cy[0] - py, r) ||
           dist_lt(cx[1] - px, cy[1] - py, r);
  endfunction

  function automatic bit caps_aligned(longint ax, longint ay, longint ar, longint ad,
                                      longint bx, longint by, longint br, longint bd);
    if (ax - ar > bx + br) return 1'b0;
    if (ax + ar < bx - br) return 1'b0;
    if (ay - ad < by + bd && ay + ad > by - bd) return 1'b1;
    return dist_lt(ax - bx, (ay + ad) - (by - bd), ar + br) ||
           dist_lt(ax - bx, (ay - ad) - (by + bd), ar + br);
  endfunction

  function automatic bit ordered_overlap(shape_t a, shape_t b);
    longint abw, abh, acx[2], acy[2], ar, bbw, bbh, bcx[2], bcy[2], br;
    if (a.kind == spo_pkg::KIND_BOX && b.kind == spo_pkg::KIND_BOX)
      return box_box(a.x, a.y, a.hw, a.hh, b.x, b.y, b.hw, b.hh);
    if (a.kind == spo_pkg::KIND_BOX && b.kind == spo_pkg::KIND_CIRCLE)
      return box_circ(a.x, a.y, a.hw, a.hh, b.x, b.y, b.hw);
    if (a.kind == spo_pkg::KIND_CIRCLE && b.kind == spo_pkg::KIND_CIRCLE)
      return dist_lt(a.x - b.x, a.y - b.y, a.hw + b.hw);
    cap_parts(b, bbw, bbh, bcx, bcy, br);
    if (a.kind == spo_pkg::KIND_BOX)
      return box_box(a.x, a.y, a.hw, a.hh, b.x, b.y, bbw, bbh) ||
             box_circ(a.x, a.y, a.hw, a.hh, bcx[0], bcy[0], br) ||
             box_circ(a.x, a.y, a.hw, a.hh, bcx[1], bcy[1], br);
    if (a.kind == spo_pkg::KIND_CIRCLE)
      return dist_lt(a.x - bcx[0], a.y - bcy[0], a.hw + br) ||
             dist_lt(a.x - bcx[1], a.y - bcy[1], a.hw + br) ||
             box_circ(b.x, b.y, bbw, bbh, a.x, a.y, a.hw);
    if (a.kind == b.kind) begin
      if (a.kind == spo_pkg::KIND_VCAP)
        return caps_aligned(a.x, a.y, a.hw, cap_len(a), b.x, b.y, b.hw, cap_len(b));
      return caps_aligned(a.y, a.x, a.hh, cap_len(a), b.y, b.x, b.hh, cap_len(b));
    end
    cap_parts(a, abw, abh, acx, acy, ar);
    if (box_box(a.x, a.y, abw, abh, b.x, b.y, bbw, bbh)) return 1'b1;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (dist_lt(acx[i] - bcx[j], acy[i] - bcy[j], ar + br)) return 1'b1;
    for (int i = 0; i < 2; i++) begin
      if (box_circ(a.x, a.y, abw, abh, bcx[i], bcy[i], br)) return 1'b1;
      if (box_circ(b.x, b.y, bbw, bbh, acx[i], acy[i], ar)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit pair_overlap(shape_t a, shape_t b);
    if (a.kind > spo_pkg::KIND_POINT || b.kind > spo_pkg::KIND_POINT) return 1'b0;
    if (a.kind == spo_pkg::KIND_POINT && b.kind == spo_pkg::KIND_POINT) return 1'b0;
    if (a.kind == spo_pkg::KIND_POINT) return shape_has_point(b, a.x, a.y);
    if (b.kind == spo_pkg::KIND_POINT) return shape_has_point(a, b.x, b.y);
    if (a.kind <= b.kind) return ordered_overlap(a, b);
    return ordered_overlap(b, a);
  endfunction

  function automatic shape_t mk(logic [2:0] kind, longint x, longint y,
                                longint hw, longint hh);
    shape_t s;
    s.kind = kind; s.x = x; s.y = y; s.hw = hw; s.hh = hh;
    return s;
  endfunction

  task automatic send_pair(shape_t a, shape_t b);
    while ($urandom_range(99) < idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    a_kind_i <= a.kind; a_x_i <= CB'(a.x); a_y_i <= CB'(a.y);
    a_hw_i <= (CB-1)'(a.hw); a_hh_i <= (CB-1)'(a.hh);
    b_kind_i <= b.kind; b_x_i <= CB'(b.x); b_y_i <= CB'(b.y);
    b_hw_i <= (CB-1)'(b.hw); b_hh_i <= (CB-1)'(b.hh);
    do @(posedge clk_i); while (full_o);
    expected_overlap = {expected_overlap, pair_overlap(a, b)};
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_overlap.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result overlap=%0b", overlap_o);
      end else begin
        exp_bit = expected_overlap.pop_front();
        if (exp_bit !== overlap_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("overlap mismatch: expected %0b actual %0b", exp_bit, overlap_o);
        end
      end
    end
    pop_i <= ($urandom_range(99) >= idle_pct);
  end

  function automatic shape_t rand_shape(int span, bit any_bits);
    shape_t s;
    s.kind = any_bits ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    if (any_bits) begin
      s.x = longint'($signed(16'($urandom))); s.y = longint'($signed(16'($urandom)));
      s.hw = $urandom_range(32767); s.hh = $urandom_range(32767);
    end else begin
      s.x = $signed($urandom_range(2 * span)) - span;
      s.y = $signed($urandom_range(2 * span)) - span;
      s.hw = $urandom_range(span / 2); s.hh = $urandom_range(span / 2);
    end
    return s;
  endfunction

  task automatic test_special_cases();
    send_pair(mk(spo_pkg::KIND_BOX, 0, 0, 10, 10), mk(spo_pkg::KIND_CIRCLE, 10, 0, 1, 0));
    send_pair(mk(spo_pkg::KIND_BOX, 0, 0, 10, 10), mk(spo_pkg::KIND_CIRCLE, 10, 0, 0, 0));
    send_pair(mk(spo_pkg::KIND_CIRCLE, 13, 14, 5, 0), mk(spo_pkg::KIND_BOX, 0, 0, 10, 10));
    send_pair(mk(spo_pkg::KIND_POINT, 0, 0, 0, 0), mk(spo_pkg::KIND_POINT, 0, 0, 0, 0));
    send_pair(mk(3'd5, 0, 0, 9, 9), mk(spo_pkg::KIND_BOX, 0, 0, 9, 9));
    send_pair(mk(spo_pkg::KIND_BOX, 0, 0, 9, 9), mk(3'd7, 0, 0, 9, 9));
    send_pair(mk(spo_pkg::KIND_BOX, 0, 0, 0, 0), mk(spo_pkg::KIND_POINT, 0, 0, 0, 0));
    send_pair(mk(spo_pkg::KIND_VCAP, 0, 0, 5, 20), mk(spo_pkg::KIND_VCAP, 9, 40, 5, 30));
    send_pair(mk(spo_pkg::KIND_HCAP, 0, 0, 20, 5), mk(spo_pkg::KIND_HCAP, 40, 9, 30, 5));
    send_pair(mk(spo_pkg::KIND_VCAP, 0, 0, 5, 20), mk(spo_pkg::KIND_HCAP, 20, 25, 15, 4));
    send_pair(mk(spo_pkg::KIND_HCAP, 3, 3, 2, 9), mk(spo_pkg::KIND_POINT, 3, 12, 0, 0));
    send_pair(mk(spo_pkg::KIND_POINT, 0, 18, 0, 0), mk(spo_pkg::KIND_VCAP, 0, 0, 5, 15));
    send_pair(mk(spo_pkg::KIND_CIRCLE, 0, 0, 5, 0), mk(spo_pkg::KIND_VCAP, 0, 30, 5, 25));
    send_pair(mk(spo_pkg::KIND_CIRCLE, -32768, -32768, 32767, 32767),
              mk(spo_pkg::KIND_CIRCLE, 32767, 32767, 32767, 32767));
    send_pair(mk(spo_pkg::KIND_BOX, 32767, -32768, 32767, 32767),
              mk(spo_pkg::KIND_HCAP, -32768, 32767, 32767, 0));
    send_pair(mk(spo_pkg::KIND_VCAP, -32768, 32767, 0, 32767),
              mk(spo_pkg::KIND_HCAP, 32767, -32768, 32767, 32767));
    send_pair(mk(spo_pkg::KIND_BOX, 0, 0, 32767, 32767),
              mk(spo_pkg::KIND_BOX, 1, 1, 0, 32767));
  endtask

  task automatic test_random_pairs(int count);
    int span;
    bit raw;
    for (int n = 0; n < count; n++) begin
      raw = ($urandom_range(9) == 0);
      span = ($urandom_range(3) == 0) ? 30000 : 60;
      send_pair(rand_shape(span, raw), rand_shape(span, raw));
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_pct = 0;
    test_random_pairs(count);
    idle_pct = 36;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_random_pairs(800);
    test_back_to_back(250);
    test_random_pairs(700);
    push_i <= 1'b0;
    while (expected_overlap.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/spo_pkg.sv
rtl/spo_fifo.sv
rtl/spo_front.sv
rtl/spo_back.sv
rtl/shape_pair_overlap_test.sv
rtl/spo_checker.sv
verif/shape_pair_overlap_test_tb.sv
